### design/vtt_pkg.sv
// vtt_pkg: shared types, constants and float helpers for vertex_tint_and_translate
// no dependencies; imported by every module of the block

package vtt_pkg;

   localparam int CSR_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TINT_ENABLE = 3'd0,
      CSR_TINT_RGB    = 3'd1,
      CSR_OFFSET_X    = 3'd2,
      CSR_OFFSET_Y    = 3'd3,
      CSR_OFFSET_Z    = 3'd4
   } csr_index_type;

   localparam logic [31:0] FP_QNAN    = 32'h7FC0_0000;
   localparam logic [30:0] FP_INF_MAG = 31'h7F80_0000;
   localparam logic [31:0] FP_ONE     = 32'h3F80_0000;

   typedef struct packed {
      logic [31:0] pos_x;
      logic [31:0] pos_y;
      logic [31:0] pos_z;
      logic [31:0] color_word;
      logic [31:0] tex_u;
      logic [31:0] tex_v;
      logic [31:0] brightness;
      logic [31:0] shade_factor;
   } req_type;

   typedef struct packed {
      logic [31:0] out_pos_x;
      logic [31:0] out_pos_y;
      logic [31:0] out_pos_z;
      logic [31:0] out_color_word;
      logic [31:0] out_tex_u;
      logic [31:0] out_tex_v;
      logic [31:0] out_light;
   } rsp_type;

   typedef struct packed {
      logic        tint_enable;
      logic [23:0] tint_rgb;
      logic [31:0] off_x;
      logic [31:0] off_y;
      logic [31:0] off_z;
   } csr_cfg_type;

   typedef logic [31:0] tint_lut_type [256];

   // single precision value of k / 255, nearest even
   function automatic tint_lut_type build_tint_lut();
      tint_lut_type t;
      longint num;
      longint q;
      longint r;
      int     n;
      int     ex;
      for (int k = 0; k < 256; k++) begin
         if (k == 0) begin
            t[k] = 32'h0;
         end else if (k == 255) begin
            t[k] = FP_ONE;
         end else begin
            n = 8;
            for (int j = 8; j >= 1; j--) begin
               if ((longint'(k) << j) >= 255) n = j;
            end
            num = longint'(k) << (n + 23);
            q   = num / 255;
            r   = num % 255;
            if (2 * r > 255) q = q + 1;
            ex = 127 - n;
            if (q == (64'sd1 << 24)) begin
               q  = q >> 1;
               ex = ex + 1;
            end
            t[k] = {1'b0, 8'(ex), 23'(q)};
         end
      end
      return t;
   endfunction

   localparam tint_lut_type TINT_LUT = build_tint_lut();

   // round to nearest even and pack, bp is the biased exponent (at least 1)
   function automatic logic [31:0] round_pack(logic s, int bp, logic [23:0] m, logic g,
                                              logic st);
      logic        up;
      logic [24:0] m2;
      int          ef;
      up = g & (st | m[0]);
      m2 = {1'b0, m} + 25'(up);
      if (m2[24]) ef = bp + 1;
      else if (m2[23]) ef = bp;
      else ef = 0;
      if (ef >= 255) return {s, FP_INF_MAG};
      return {s, 8'(ef), m2[22:0]};
   endfunction

endpackage

### design/vtt_csr.sv
// vtt_csr: configuration registers, offsets rounded to single on write
// depends on vtt_pkg

module vtt_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [vtt_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [63:0]                   csr_wdata,
   output vtt_pkg::csr_cfg_type          cfg
);
   import vtt_pkg::*;

   csr_cfg_type cfg_ff;
   csr_cfg_type cfg_in;
   logic [31:0] off_single;

   function automatic logic [31:0] dbl_to_sgl(logic [63:0] b);
      logic        s;
      logic [10:0] e;
      logic [63:0] mant;
      logic [63:0] t;
      logic [23:0] m;
      logic        g;
      logic        st;
      int          be;
      int          bp;
      int          sh;
      s    = b[63];
      e    = b[62:52];
      mant = {11'b0, 1'b1, b[51:0]};
      if (e == 11'h7FF) begin
         if (b[51:0] != 52'h0) return 32'h0;
         return {s, FP_INF_MAG};
      end
      if (e == 11'h0) return {s, 31'h0};
      be = int'(e) - 896;
      bp = (be < 1) ? 1 : be;
      sh = 29 + bp - be;
      if (sh > 60) begin
         m  = 24'h0;
         g  = 1'b0;
         st = 1'b1;
      end else begin
         t  = mant >> (sh - 1);
         m  = t[24:1];
         g  = t[0];
         st = |(mant & ((64'd1 << (sh - 1)) - 64'd1));
      end
      return round_pack(s, bp, m, g, st);
   endfunction

   assign csr_ready  = 1'b1;
   assign off_single = dbl_to_sgl(csr_wdata);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_TINT_ENABLE: cfg_in.tint_enable = csr_wdata[0];
            CSR_TINT_RGB:    cfg_in.tint_rgb    = csr_wdata[23:0];
            CSR_OFFSET_X:    cfg_in.off_x       = off_single;
            CSR_OFFSET_Y:    cfg_in.off_y       = off_single;
            CSR_OFFSET_Z:    cfg_in.off_z       = off_single;
            default:         cfg_in             = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tint_enable <= 1'b0;
         cfg_ff.tint_rgb    <= 24'hFF_FFFF;
         cfg_ff.off_x       <= 32'h0;
         cfg_ff.off_y       <= 32'h0;
         cfg_ff.off_z       <= 32'h0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### design/vtt_fmul.sv
// vtt_fmul: two-stage single precision multiplier, nearest even
// stage 1 mantissa product, stage 2 normalize and round; depends on vtt_pkg

module vtt_fmul (
   input  logic        clock,
   input  logic        ce,
   input  logic [31:0] a,
   input  logic [31:0] b,
   output logic [31:0] y
);
   import vtt_pkg::*;

   typedef struct packed {
      logic        sign;
      logic        nan;
      logic        inf;
      logic        zero;
      logic [8:0]  esum;
      logic [47:0] prod;
   } fmp_type;

   fmp_type     pre_ff;
   fmp_type     pre_in;
   logic [31:0] y_ff;
   logic [31:0] y_in;

   function automatic fmp_type fmul_pre(logic [31:0] x, logic [31:0] z);
      fmp_type r;
      logic    nan_x;
      logic    nan_z;
      logic    inf_x;
      logic    inf_z;
      logic    zer_x;
      logic    zer_z;
      nan_x  = (x[30:23] == 8'hFF) && (x[22:0] != 23'h0);
      nan_z  = (z[30:23] == 8'hFF) && (z[22:0] != 23'h0);
      inf_x  = x[30:0] == FP_INF_MAG;
      inf_z  = z[30:0] == FP_INF_MAG;
      zer_x  = x[30:0] == 31'h0;
      zer_z  = z[30:0] == 31'h0;
      r.sign = x[31] ^ z[31];
      r.nan  = nan_x | nan_z | (inf_x & zer_z) | (inf_z & zer_x);
      r.inf  = inf_x | inf_z;
      r.zero = zer_x | zer_z;
      r.esum = 9'((x[30:23] == 8'h0) ? 8'd1 : x[30:23])
             + 9'((z[30:23] == 8'h0) ? 8'd1 : z[30:23]);
      r.prod = 48'({x[30:23] != 8'h0, x[22:0]}) * 48'({z[30:23] != 8'h0, z[22:0]});
      return r;
   endfunction

   function automatic logic [31:0] fmul_post(fmp_type p);
      logic [63:0] p64;
      logic [63:0] t;
      logic [23:0] m;
      logic        g;
      logic        st;
      int          lead;
      int          ex;
      int          be;
      int          bp;
      int          sh;
      if (p.nan) return FP_QNAN;
      if (p.inf) return {p.sign, FP_INF_MAG};
      if (p.zero) return {p.sign, 31'h0};
      lead = 0;
      for (int i = 0; i < 48; i++) begin
         if (p.prod[i]) lead = i;
      end
      p64 = {16'h0, p.prod};
      ex  = int'(p.esum);
      be  = lead + ex - 173;
      bp  = (be < 1) ? 1 : be;
      sh  = bp + 150 - ex;
      if (sh <= 0) begin
         t  = p64 << (-sh);
         m  = t[23:0];
         g  = 1'b0;
         st = 1'b0;
      end else if (sh > 49) begin
         m  = 24'h0;
         g  = 1'b0;
         st = |p.prod;
      end else begin
         t  = p64 >> (sh - 1);
         m  = t[24:1];
         g  = t[0];
         st = |(p64 & ((64'd1 << (sh - 1)) - 64'd1));
      end
      return round_pack(p.sign, bp, m, g, st);
   endfunction

   assign pre_in = fmul_pre(a, b);
   assign y_in   = fmul_post(pre_ff);

   always_ff @(posedge clock) begin
      if (ce) begin
         pre_ff <= pre_in;
         y_ff   <= y_in;
      end
   end

   assign y = y_ff;

endmodule

### design/vtt_fadd.sv
// vtt_fadd: three-stage single precision adder, nearest even
// align, add with leading-one search, normalize and round; depends on vtt_pkg

module vtt_fadd (
   input  logic        clock,
   input  logic        ce,
   input  logic [31:0] a,
   input  logic [31:0] b,
   output logic [31:0] y
);
   import vtt_pkg::*;

   typedef struct packed {
      logic        nan;
      logic        inf;
      logic        inf_sign;
      logic        sign;
      logic        zsign;
      logic        sub;
      logic [7:0]  ebig;
      logic [26:0] big;
      logic [26:0] small_m;
   } faa_type;

   typedef struct packed {
      logic        nan;
      logic        inf;
      logic        inf_sign;
      logic        sign;
      logic        zsign;
      logic [7:0]  ebig;
      logic [27:0] sum;
      logic [4:0]  lead;
   } fab_type;

   faa_type     al_ff;
   faa_type     al_in;
   fab_type     sm_ff;
   fab_type     sm_in;
   logic [31:0] y_ff;
   logic [31:0] y_in;

   function automatic faa_type fadd_align(logic [31:0] x, logic [31:0] z);
      faa_type     r;
      logic [31:0] hi;
      logic [31:0] lo;
      logic        nan_x;
      logic        nan_z;
      logic        inf_x;
      logic        inf_z;
      logic [7:0]  elo;
      logic [26:0] lo27;
      int          d;
      nan_x = (x[30:23] == 8'hFF) && (x[22:0] != 23'h0);
      nan_z = (z[30:23] == 8'hFF) && (z[22:0] != 23'h0);
      inf_x = x[30:0] == FP_INF_MAG;
      inf_z = z[30:0] == FP_INF_MAG;
      if (x[30:0] >= z[30:0]) begin
         hi = x;
         lo = z;
      end else begin
         hi = z;
         lo = x;
      end
      r.nan      = nan_x | nan_z | (inf_x & inf_z & (x[31] ^ z[31]));
      r.inf      = inf_x | inf_z;
      r.inf_sign = inf_x ? x[31] : z[31];
      r.sign     = hi[31];
      r.zsign    = x[31] & z[31];
      r.sub      = x[31] ^ z[31];
      r.ebig     = (hi[30:23] == 8'h0) ? 8'd1 : hi[30:23];
      elo        = (lo[30:23] == 8'h0) ? 8'd1 : lo[30:23];
      r.big      = {hi[30:23] != 8'h0, hi[22:0], 3'b000};
      lo27       = {lo[30:23] != 8'h0, lo[22:0], 3'b000};
      d          = int'(r.ebig) - int'(elo);
      if (d >= 27) begin
         r.small_m = {26'h0, |lo27};
      end else begin
         r.small_m = (lo27 >> d) | 27'(|(lo27 & ((27'd1 << d) - 27'd1)));
      end
      return r;
   endfunction

   function automatic fab_type fadd_sum(faa_type p);
      fab_type r;
      r.nan      = p.nan;
      r.inf      = p.inf;
      r.inf_sign = p.inf_sign;
      r.sign     = p.sign;
      r.zsign    = p.zsign;
      r.ebig     = p.ebig;
      r.sum      = p.sub ? ({1'b0, p.big} - {1'b0, p.small_m})
                         : ({1'b0, p.big} + {1'b0, p.small_m});
      r.lead     = 5'h0;
      for (int i = 0; i < 28; i++) begin
         if (r.sum[i]) r.lead = 5'(i);
      end
      return r;
   endfunction

   function automatic logic [31:0] fadd_round(fab_type p);
      logic [27:0] n;
      logic        lost;
      int          be;
      int          bp;
      int          shl;
      if (p.nan) return FP_QNAN;
      if (p.inf) return {p.inf_sign, FP_INF_MAG};
      if (p.sum == 28'h0) return {p.zsign, 31'h0};
      be  = int'(p.lead) + int'(p.ebig) - 26;
      bp  = (be < 1) ? 1 : be;
      shl = int'(p.ebig) - bp;
      if (shl < 0) begin
         n    = {1'b0, p.sum[27:1]};
         lost = p.sum[0];
      end else begin
         n    = p.sum << shl;
         lost = 1'b0;
      end
      return round_pack(p.sign, bp, n[26:3], n[2], n[1] | n[0] | lost);
   endfunction

   assign al_in = fadd_align(a, b);
   assign sm_in = fadd_sum(al_ff);
   assign y_in  = fadd_round(sm_ff);

   always_ff @(posedge clock) begin
      if (ce) begin
         al_ff <= al_in;
         sm_ff <= sm_in;
         y_ff  <= y_in;
      end
   end

   assign y = y_ff;

endmodule

### design/vertex_tint_and_translate.sv
// throughput: one vertex per cycle when no held response stalls the pipeline,
// set by the fully pipelined float units
// stages: input reg, tint multiply (2), channel multiply (2), clamp and output reg
// positions go through a 3-stage adder and are delayed to match
// reset is synchronous: pipeline valids cleared, tint off, tint white, offsets zero

module vertex_tint_and_translate (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  vtt_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output vtt_pkg::rsp_type              rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [vtt_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [63:0]                   csr_wdata
);
   import vtt_pkg::*;

   localparam int DEPTH = 6;

   csr_cfg_type       cfg;
   logic              advance;
   logic [DEPTH-1:0]  vld_ff;
   logic [DEPTH-1:0]  vld_in;
   req_type           pl_ff [5];
   logic [31:0]       tint [3];
   logic [31:0]       shade [3];
   logic [31:0]       chan_f [3];
   logic [31:0]       prod [3];
   logic [31:0]       offs [3];
   logic [31:0]       pos_in [3];
   logic [31:0]       pos_sum [3];
   logic [31:0]       pos_d_ff [3];
   logic [7:0]        chan_q [3];
   rsp_type           out_ff;
   rsp_type           out_in;

   function automatic logic [31:0] byte_to_float(logic [7:0] c);
      int lead;
      if (c == 8'h0) return 32'h0;
      lead = 0;
      for (int i = 0; i < 8; i++) begin
         if (c[i]) lead = i;
      end
      return {1'b0, 8'(127 + lead), 23'({15'h0, c} << (23 - lead))};
   endfunction

   function automatic logic [7:0] clamp_trunc(logic [31:0] p);
      logic [23:0] m;
      if (p[31] || (p[30:23] == 8'hFF && p[22:0] != 23'h0) || p[30:23] < 8'd127)
         return 8'h0;
      if (p[30:0] >= 31'h437F_0000) return 8'hFF;
      m = {1'b1, p[22:0]} >> (8'd150 - p[30:23]);
      return m[7:0];
   endfunction

   vtt_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   assign advance   = !(vld_ff[DEPTH-1] && rsp_stall);
   assign req_stall = !advance;
   assign vld_in    = {vld_ff[DEPTH-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pl_ff[0] <= req_data;
         for (int i = 1; i < 5; i++) pl_ff[i] <= pl_ff[i-1];
         for (int i = 0; i < 3; i++) pos_d_ff[i] <= pos_sum[i];
         out_ff <= out_in;
      end
   end

   always_comb begin
      tint[0] = cfg.tint_enable ? TINT_LUT[cfg.tint_rgb[23:16]] : FP_ONE;
      tint[1] = cfg.tint_enable ? TINT_LUT[cfg.tint_rgb[15:8]]  : FP_ONE;
      tint[2] = cfg.tint_enable ? TINT_LUT[cfg.tint_rgb[7:0]]   : FP_ONE;
      for (int i = 0; i < 3; i++) chan_f[i] = byte_to_float(pl_ff[2].color_word[8*i +: 8]);
      pos_in[0] = pl_ff[0].pos_x;
      pos_in[1] = pl_ff[0].pos_y;
      pos_in[2] = pl_ff[0].pos_z;
      offs[0]   = cfg.off_x;
      offs[1]   = cfg.off_y;
      offs[2]   = cfg.off_z;
   end

   for (genvar i = 0; i < 3; i++) begin : g_lane
      vtt_fmul u_tint_mul (
         .clock (clock),
         .ce    (advance),
         .a     (pl_ff[0].shade_factor),
         .b     (tint[i]),
         .y     (shade[i])
      );
      vtt_fmul u_chan_mul (
         .clock (clock),
         .ce    (advance),
         .a     (chan_f[i]),
         .b     (shade[i]),
         .y     (prod[i])
      );
      vtt_fadd u_pos_add (
         .clock (clock),
         .ce    (advance),
         .a     (pos_in[i]),
         .b     (offs[i]),
         .y     (pos_sum[i])
      );
      assign chan_q[i] = clamp_trunc(prod[i]);
   end

   always_comb begin
      out_in.out_pos_x      = pos_d_ff[0];
      out_in.out_pos_y      = pos_d_ff[1];
      out_in.out_pos_z      = pos_d_ff[2];
      out_in.out_color_word = {pl_ff[4].color_word[31:24], chan_q[2], chan_q[1], chan_q[0]};
      out_in.out_tex_u      = pl_ff[4].tex_u;
      out_in.out_tex_v      = pl_ff[4].tex_v;
      out_in.out_light      = pl_ff[4].brightness;
   end

   assign rsp_valid = vld_ff[DEPTH-1];
   assign rsp_data  = out_ff;

   a_accept_enters : assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> vld_ff[0])
      else $error("accepted transaction did not enter the pipeline");

   a_backpressure : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("request taken while response is held");

   a_valid_moves : assert property (@(posedge clock) disable iff (reset)
      !req_stall |=> vld_ff[DEPTH-1] == $past(vld_ff[DEPTH-2]))
      else $error("pipeline valid lost or duplicated");

endmodule
